// ===== rtl/core/vaps_pkg.sv =====
// ----------------------------------------------------------------------------
// vaps_pkg
// Shared types and codes for the voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package vaps_pkg;
  localparam logic [1:0] OP_PLAY  = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_NOVOICE = 2'd2;

  typedef struct packed {
    logic       start;
    logic       scan_free;
    logic       scan_steal;
    logic       scan_tick;
    logic       finish;
  } vaps_cmd_t;

  typedef struct packed {
    logic       scan_last;
  } vaps_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/vaps_ctrl.sv =====
// ----------------------------------------------------------------------------
// vaps_ctrl
// Sequencer: accepts an item, walks the voice table for play and tick, presents the result.
// ----------------------------------------------------------------------------
`default_nettype none
module vaps_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire logic [1:0]         opcode_i,
  output vaps_pkg::vaps_cmd_t     cmd_o,
  input  wire vaps_pkg::vaps_sts_t sts_i
);
  import vaps_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_FREE, S_STEAL, S_TICK, S_FIN, S_OUT} state_e;
  state_e state_q;

  logic accept;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = !(state_q == S_IDLE || (state_q == S_OUT && !out_stall));
  assign out_valid = (state_q == S_OUT);

  always_comb begin
    cmd_o            = '0;
    cmd_o.start      = accept;
    cmd_o.scan_free  = (state_q == S_FREE);
    cmd_o.scan_steal = (state_q == S_STEAL);
    cmd_o.scan_tick  = (state_q == S_TICK);
    cmd_o.finish     = (state_q == S_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_FREE:  if (sts_i.scan_last) state_q <= S_STEAL;
        S_STEAL: if (sts_i.scan_last) state_q <= S_FIN;
        S_TICK:  if (sts_i.scan_last) state_q <= S_FIN;
        S_FIN:   state_q <= S_OUT;
        S_IDLE, S_OUT: begin
          if (accept) begin
            case (opcode_i)
              OP_PLAY: state_q <= S_FREE;
              OP_TICK: state_q <= S_TICK;
              default: state_q <= S_FIN;
            endcase
          end else if (state_q == S_OUT && !out_stall) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/vaps_dp.sv =====
// ----------------------------------------------------------------------------
// vaps_dp
// Voice table, scan pointer, candidate registers and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module vaps_dp #(
  parameter int VOICES          = 32,
  parameter int RESIDENT_VOICES = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire vaps_pkg::vaps_cmd_t  cmd_i,
  output vaps_pkg::vaps_sts_t       sts_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [31:0]          now_frame_i,
  input  wire logic [15:0]          priority_req_i,
  input  wire logic                 looping_i,
  input  wire logic [30:0]          duration_frames_i,
  input  wire logic [4:0]           voice_slot_i,
  input  wire logic [15:0]          voice_generation_i,
  output logic [1:0]                status_o,
  output logic [4:0]                slot_out_o,
  output logic [15:0]               generation_out_o,
  output logic                      stolen_o,
  output logic [31:0]               released_mask_o,
  output logic                      playing_o,
  output logic [31:0]               steal_total_o,
  output logic [31:0]               fail_total_o
);
  import vaps_pkg::*;

  localparam int NRES = (RESIDENT_VOICES > VOICES) ? VOICES : RESIDENT_VOICES;
  localparam int IW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [IW-1:0] LAST = IW'(NRES - 1);

  logic [VOICES-1:0] act_q, loop_q;
  logic [15:0] prio_q [VOICES];
  logic [31:0] ser_q  [VOICES];
  logic [31:0] end_q  [VOICES];
  logic [15:0] gen_q  [VOICES];
  logic [31:0] serial_q, steal_q, fail_q;

  logic [1:0]  op_q;
  logic [31:0] now_q;
  logic [15:0] preq_q;
  logic        lreq_q;
  logic [30:0] dur_q;
  logic [4:0]  vslot_q;
  logic [15:0] vgen_q;

  logic [IW-1:0] idx_q;
  logic          found_q;
  logic [IW-1:0] best_q;
  logic [15:0]   bprio_q;
  logic [31:0]   bser_q;
  logic [31:0]   mask_q;

  logic [IW-1:0] vs;
  logic          slot_ok, hmatch, cand, better;
  logic [15:0]   ngen;
  logic [31:0]   diff;

  assign sts_o.scan_last = (idx_q == LAST);
  assign vs      = vslot_q[IW-1:0];
  assign slot_ok = ({27'd0, vslot_q} < 32'(VOICES));
  assign hmatch  = slot_ok && act_q[vs] && (gen_q[vs] == vgen_q);
  assign cand    = act_q[idx_q] && !loop_q[idx_q] && (prio_q[idx_q] <= preq_q);
  assign better  = !found_q || (prio_q[idx_q] < bprio_q) ||
                   (prio_q[idx_q] == bprio_q && ser_q[idx_q] < bser_q);
  assign ngen    = (gen_q[best_q] == 16'hFFFF) ? 16'd1 : gen_q[best_q] + 16'd1;
  assign diff    = now_q - end_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= '0;
      loop_q   <= '0;
      serial_q <= '0;
      steal_q  <= '0;
      fail_q   <= '0;
      for (int i = 0; i < VOICES; i++) begin
        prio_q[i] <= '0;
        ser_q[i]  <= '0;
        end_q[i]  <= '0;
        gen_q[i]  <= '0;
      end
    end else if (cmd_i.finish) begin
      case (op_q)
        OP_PLAY: begin
          if (found_q) begin
            if (act_q[best_q]) steal_q <= steal_q + 32'd1;
            act_q[best_q]  <= 1'b1;
            loop_q[best_q] <= lreq_q;
            prio_q[best_q] <= preq_q;
            gen_q[best_q]  <= ngen;
            ser_q[best_q]  <= serial_q + 32'd1;
            end_q[best_q]  <= now_q + {1'b0, dur_q};
            serial_q       <= serial_q + 32'd1;
          end else begin
            fail_q <= fail_q + 32'd1;
          end
        end
        OP_STOP: if (hmatch) act_q[vs] <= 1'b0;
        OP_TICK: act_q <= act_q & ~mask_q[VOICES-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q    <= opcode_i;
      now_q   <= now_frame_i;
      preq_q  <= priority_req_i;
      lreq_q  <= looping_i;
      dur_q   <= duration_frames_i;
      vslot_q <= voice_slot_i;
      vgen_q  <= voice_generation_i;
      idx_q   <= '0;
      found_q <= 1'b0;
      best_q  <= '0;
      bprio_q <= '0;
      bser_q  <= '0;
      mask_q  <= '0;
    end else if (cmd_i.scan_free) begin
      if (!found_q && !act_q[idx_q]) begin
        found_q <= 1'b1;
        best_q  <= idx_q;
      end
      idx_q <= sts_o.scan_last ? '0 : idx_q + 1'b1;
    end else if (cmd_i.scan_steal) begin
      if (!(found_q && !act_q[best_q]) && cand && better) begin
        found_q <= 1'b1;
        best_q  <= idx_q;
        bprio_q <= prio_q[idx_q];
        bser_q  <= ser_q[idx_q];
      end
      idx_q <= idx_q + 1'b1;
    end else if (cmd_i.scan_tick) begin
      if (act_q[idx_q] && !loop_q[idx_q] && !diff[31]) mask_q[idx_q] <= 1'b1;
      idx_q <= idx_q + 1'b1;
    end else if (cmd_i.finish) begin
      status_o         <= ST_OK;
      slot_out_o       <= '0;
      generation_out_o <= '0;
      stolen_o         <= 1'b0;
      released_mask_o  <= '0;
      playing_o        <= 1'b0;
      case (op_q)
        OP_PLAY: begin
          if (found_q) begin
            slot_out_o       <= 5'(best_q);
            generation_out_o <= ngen;
            stolen_o         <= act_q[best_q];
            if (act_q[best_q]) released_mask_o <= 32'd1 << best_q;
          end else begin
            status_o <= ST_NOVOICE;
          end
        end
        OP_STOP: begin
          if (hmatch) released_mask_o <= 32'd1 << vslot_q;
          else        status_o <= ST_BAD;
        end
        OP_TICK:  released_mask_o <= mask_q;
        default:  playing_o <= hmatch;
      endcase
    end
  end

  always_comb begin
    steal_total_o = steal_q;
    fail_total_o  = fail_q;
  end
endmodule
`default_nettype wire

// ===== rtl/core/voice_allocator_priority_steal_top.sv =====
// Play scans the first RESIDENT_VOICES entries (at most VOICES) for a free
// voice, then again for a steal candidate; tick scans them once; stop and query
// skip the scan. One item in flight at a time; the scan covers one entry a cycle.
// Reset clears the whole voice table and the serial, steal and fail counters at once.
// ----------------------------------------------------------------------------
// voice_allocator_priority_steal_top
// Voice allocator with priority stealing: sequencer plus voice table.
// ----------------------------------------------------------------------------
`default_nettype none
module voice_allocator_priority_steal_top #(
  parameter int VOICES          = 32,
  parameter int RESIDENT_VOICES = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] now_frame_i,
  input  wire logic [15:0] priority_req_i,
  input  wire logic        looping_i,
  input  wire logic [30:0] duration_frames_i,
  input  wire logic [4:0]  voice_slot_i,
  input  wire logic [15:0] voice_generation_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status_o,
  output logic [4:0]       slot_out_o,
  output logic [15:0]      generation_out_o,
  output logic             stolen_o,
  output logic [31:0]      released_mask_o,
  output logic             playing_o,
  output logic [31:0]      steal_total_o,
  output logic [31:0]      fail_total_o
);
  import vaps_pkg::*;

  vaps_cmd_t cmd;
  vaps_sts_t sts;

  vaps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .opcode_i, .cmd_o(cmd), .sts_i(sts)
  );

  vaps_dp #(.VOICES(VOICES), .RESIDENT_VOICES(RESIDENT_VOICES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .opcode_i, .now_frame_i, .priority_req_i, .looping_i, .duration_frames_i,
    .voice_slot_i, .voice_generation_i,
    .status_o, .slot_out_o, .generation_out_o, .stolen_o, .released_mask_o,
    .playing_o, .steal_total_o, .fail_total_o
  );
endmodule
`default_nettype wire
